// ----- rtl/pot_pkg.sv -----
// Shared definitions for the polygon orientation test.
// Holds the port width, the coordinate width default and the request record
// that passes from the vertex tracker to the cross-product pipeline.
`timescale 1ns / 1ps

package pot_pkg;

    // Width of the coordinate ports.
    localparam int FIELD_BITS = 32;

    // Default number of low coordinate bits in use.
    localparam int COORD_BITS_DEF = 32;

    // Control part of one orientation request.
    typedef struct packed {
        logic valid;
        logic too_few;
    } corner_ctl_t;

endpackage

// ----- rtl/pot_cross_sign.sv -----
// Cross-product sign pipeline of the polygon orientation test.
// Takes the corner and its two neighbours and returns the orientation result.
// Depends on pot_pkg.
`timescale 1ns / 1ps

module pot_cross_sign
    import pot_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  corner_ctl_t                  req_ctl,
    output logic                         req_ready,
    input  logic signed [COORD_BITS-1:0] a_x,
    input  logic signed [COORD_BITS-1:0] a_y,
    input  logic signed [COORD_BITS-1:0] b_x,
    input  logic signed [COORD_BITS-1:0] b_y,
    input  logic signed [COORD_BITS-1:0] c_x,
    input  logic signed [COORD_BITS-1:0] c_y,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_is_clockwise,
    output logic                         m_too_few_points
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    // Difference stage.
    logic                 d_vld_reg;
    logic                 d_few_reg;
    logic signed [DW-1:0] bx_reg, by_reg, cx_reg, cy_reg;
    // Product stage.
    logic                 p_vld_reg;
    logic                 p_few_reg;
    logic signed [PW-1:0] p1_reg, p2_reg;
    // Result stage.
    logic                 o_vld_reg;
    logic                 o_cw_reg;
    logic                 o_few_reg;

    logic o_free, p_adv, p_free, d_adv, d_free;

    always_comb begin
        o_free    = !o_vld_reg || m_ready;
        p_adv     = p_vld_reg && o_free;
        p_free    = !p_vld_reg || p_adv;
        d_adv     = d_vld_reg && p_free;
        d_free    = !d_vld_reg || d_adv;
        req_ready = d_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_vld_reg <= 1'b0;
            p_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end else begin
            if (d_free) begin
                d_vld_reg <= req_ctl.valid;
            end
            if (p_free) begin
                p_vld_reg <= d_vld_reg;
            end
            if (o_free) begin
                o_vld_reg <= p_vld_reg;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (d_free && req_ctl.valid) begin
            d_few_reg <= req_ctl.too_few;
            bx_reg    <= DW'(b_x) - DW'(a_x);
            by_reg    <= DW'(b_y) - DW'(a_y);
            cx_reg    <= DW'(c_x) - DW'(a_x);
            cy_reg    <= DW'(c_y) - DW'(a_y);
        end
        if (d_adv) begin
            p_few_reg <= d_few_reg;
            p1_reg    <= PW'(bx_reg) * PW'(cy_reg);
            p2_reg    <= PW'(by_reg) * PW'(cx_reg);
        end
        if (p_adv) begin
            o_few_reg <= p_few_reg;
            o_cw_reg  <= !p_few_reg && (p1_reg < p2_reg);
        end
    end

    assign m_valid          = o_vld_reg;
    assign m_is_clockwise   = o_cw_reg;
    assign m_too_few_points = o_few_reg;

endmodule

// ----- rtl/polygon_orientation_test.sv -----
// Polygon orientation test, top level.
// Holds the input register and the bottom-left vertex tracker; depends on
// pot_pkg and pot_cross_sign.
//
// Usage: the vertices of a polygon arrive in order on the s_ channel, one per
// request, with s_last_vertex set on the final one. Only the low COORD_BITS
// bits of each coordinate are used, taken as a signed value. No result is
// given for a vertex without the flag; the final vertex yields exactly one
// result on the m_ channel, after which tracking starts over for a new polygon.
//
// The result says whether the polygon runs clockwise, judged at the
// bottom-left vertex (least y, ties to least x, earliest wins) from the sign
// of the cross product with its neighbours. A polygon of fewer than three
// vertices gives m_too_few_points set and m_is_clockwise clear.
//
// Throughput is one vertex per cycle while s_ready is high. After the final
// vertex is accepted, its result passes the input register, where the tracker
// settles and the coordinate differences are formed, the two multipliers and
// the compare into the output register before it appears on m_valid.
//
// Reset (aresetn, synchronous, active low) empties the pipeline and clears the
// tracker. When the receiver stalls, the result is held in the output register
// and the stages behind it keep filling; only once all of them hold a result
// does s_ready drop, and then only for a final vertex waiting in the input
// register.
`timescale 1ns / 1ps

module polygon_orientation_test
    import pot_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [FIELD_BITS-1:0] s_x_coord,
    input  logic [FIELD_BITS-1:0] s_y_coord,
    input  logic                  s_last_vertex,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_is_clockwise,
    output logic                  m_too_few_points
);

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // Input register.
    logic   in_vld_reg;
    coord_t in_x_reg, in_y_reg;
    logic   in_last_reg;

    // Tracker state.
    coord_t     first_x_reg, first_y_reg, first_x_next, first_y_next;
    coord_t     prev_x_reg, prev_y_reg;
    coord_t     corner_x_reg, corner_y_reg, corner_x_next, corner_y_next;
    coord_t     before_x_reg, before_y_reg, before_x_next, before_y_next;
    coord_t     after_x_reg, after_y_reg, after_x_next, after_y_next;
    logic       at_start_reg, at_start_next;
    logic       awaiting_reg, awaiting_next;
    logic [1:0] count_reg;

    logic        req_ready;
    logic        in_go;
    logic        lower;
    corner_ctl_t req_ctl;
    coord_t      a_x, a_y, c_x, c_y;

    // A final vertex waits until the pipeline can take its request; any other
    // vertex is folded into the tracker at once.
    assign in_go   = in_vld_reg && (!in_last_reg || req_ready);
    assign s_ready = !in_vld_reg || in_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_x_reg    <= coord_t'(s_x_coord[COORD_BITS-1:0]);
            in_y_reg    <= coord_t'(s_y_coord[COORD_BITS-1:0]);
            in_last_reg <= s_last_vertex;
        end
    end

    // Strict compare, so the earliest of equal vertices stays the corner.
    assign lower = (in_y_reg < corner_y_reg) ||
                   ((in_y_reg == corner_y_reg) && (in_x_reg < corner_x_reg));

    always_comb begin
        first_x_next  = first_x_reg;
        first_y_next  = first_y_reg;
        corner_x_next = corner_x_reg;
        corner_y_next = corner_y_reg;
        before_x_next = before_x_reg;
        before_y_next = before_y_reg;
        after_x_next  = after_x_reg;
        after_y_next  = after_y_reg;
        at_start_next = at_start_reg;
        awaiting_next = awaiting_reg;
        if (count_reg == 2'd0) begin
            first_x_next  = in_x_reg;
            first_y_next  = in_y_reg;
            corner_x_next = in_x_reg;
            corner_y_next = in_y_reg;
            at_start_next = 1'b1;
            awaiting_next = 1'b1;
        end else begin
            if (awaiting_reg) begin
                after_x_next  = in_x_reg;
                after_y_next  = in_y_reg;
                awaiting_next = 1'b0;
            end
            if (lower) begin
                corner_x_next = in_x_reg;
                corner_y_next = in_y_reg;
                before_x_next = prev_x_reg;
                before_y_next = prev_y_reg;
                at_start_next = 1'b0;
                awaiting_next = 1'b1;
            end
        end
    end

    // The neighbours wrap: a corner at the start takes the final vertex as its
    // predecessor, and a corner still awaiting a successor takes the first.
    always_comb begin
        a_x             = at_start_next ? in_x_reg : before_x_next;
        a_y             = at_start_next ? in_y_reg : before_y_next;
        c_x             = awaiting_next ? first_x_next : after_x_next;
        c_y             = awaiting_next ? first_y_next : after_y_next;
        req_ctl.valid   = in_go && in_last_reg;
        req_ctl.too_few = (count_reg < 2'd2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_x_reg  <= '0;
            first_y_reg  <= '0;
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
            corner_x_reg <= '0;
            corner_y_reg <= '0;
            before_x_reg <= '0;
            before_y_reg <= '0;
            after_x_reg  <= '0;
            after_y_reg  <= '0;
            at_start_reg <= 1'b1;
            awaiting_reg <= 1'b0;
            count_reg    <= 2'd0;
        end else if (in_go) begin
            if (in_last_reg) begin
                // The polygon is complete; start over.
                first_x_reg  <= '0;
                first_y_reg  <= '0;
                prev_x_reg   <= '0;
                prev_y_reg   <= '0;
                corner_x_reg <= '0;
                corner_y_reg <= '0;
                before_x_reg <= '0;
                before_y_reg <= '0;
                after_x_reg  <= '0;
                after_y_reg  <= '0;
                at_start_reg <= 1'b1;
                awaiting_reg <= 1'b0;
                count_reg    <= 2'd0;
            end else begin
                first_x_reg  <= first_x_next;
                first_y_reg  <= first_y_next;
                prev_x_reg   <= in_x_reg;
                prev_y_reg   <= in_y_reg;
                corner_x_reg <= corner_x_next;
                corner_y_reg <= corner_y_next;
                before_x_reg <= before_x_next;
                before_y_reg <= before_y_next;
                after_x_reg  <= after_x_next;
                after_y_reg  <= after_y_next;
                at_start_reg <= at_start_next;
                awaiting_reg <= awaiting_next;
                if (count_reg != 2'd3) begin
                    count_reg <= count_reg + 2'd1;
                end
            end
        end
    end

    pot_cross_sign #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .req_ctl          (req_ctl),
        .req_ready        (req_ready),
        .a_x              (a_x),
        .a_y              (a_y),
        .b_x              (corner_x_next),
        .b_y              (corner_y_next),
        .c_x              (c_x),
        .c_y              (c_y),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_is_clockwise   (m_is_clockwise),
        .m_too_few_points (m_too_few_points)
    );

endmodule

// ----- rtl/pot_checker.sv -----
// Port-level checks for the polygon orientation test, bound to the top level.
// Watches only the handshake and result ports of polygon_orientation_test.
`timescale 1ns / 1ps

module pot_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic s_last_vertex,
    input logic m_valid,
    input logic m_ready,
    input logic m_is_clockwise,
    input logic m_too_few_points
);

    // Final vertices accepted whose results are not yet delivered.
    logic [3:0] pending_reg;
    logic       last_in, res_out;

    assign last_in = s_valid && s_ready && s_last_vertex;
    assign res_out = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 4'd0;
        end else begin
            pending_reg <= pending_reg + {3'd0, last_in} - {3'd0, res_out};
        end
    end

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_is_clockwise)
                                && $stable(m_too_few_points))
    else $error("stalled result changed");

    // Every result belongs to a final vertex that went in earlier.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_out |-> pending_reg != 4'd0)
    else $error("result without a final vertex");

    // With no polygon outstanding the input never blocks.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg == 4'd0 |-> s_ready)
    else $error("input blocked with nothing outstanding");

    // A short polygon is never reported as clockwise.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_is_clockwise && m_too_few_points))
    else $error("short polygon reported clockwise");

endmodule

bind polygon_orientation_test pot_checker u_pot_checker (.*);

// ----- sim/polygon_orientation_test_tb.sv -----
// Self-checking testbench for polygon_orientation_test.
// Streams polygons through the block and checks each orientation result against
// a predictor kept here; depends on pot_pkg and the polygon_orientation_test RTL.
`timescale 1ns / 1ps

module polygon_orientation_test_tb;
    import pot_pkg::*;

    localparam int          HALF_PERIOD  = 5;
    localparam int          RESET_CYCLES = 11;
    localparam int          RANDOM_ITEMS = 650;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          REPORT_LIMIT = 10;
    // Far beyond the slowest correct run, with every long gap and every long
    // stall taken.
    localparam longint      RUN_LIMIT_NS = 64'd4_000_000;
    localparam logic [31:0] C_MAX        = 32'h7fff_ffff;
    localparam logic [31:0] C_MIN        = 32'h8000_0000;
    localparam logic [31:0] C_ONE        = 32'h0001_0000;

    // Ways of drawing a coordinate for the random polygons.
    typedef enum int {
        COORD_FULL,
        COORD_GRID,
        COORD_EDGE,
        COORD_POOL
    } coord_mode_e;

    typedef struct {
        longint x;
        longint y;
    } point_t;

    typedef struct {
        logic clockwise;
        logic too_few;
    } orientation_t;

    // One row of the directed table. Where 'typed' is set, the expected result
    // is the one written in the row; elsewhere the predictor supplies it.
    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic        last;
        logic        typed;
        logic        clockwise;
        logic        too_few;
    } vertex_row_t;

    localparam int TABLE_ROWS = 25;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [FIELD_BITS-1:0] s_x_coord = '0;
    logic [FIELD_BITS-1:0] s_y_coord = '0;
    logic                  s_last_vertex = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_is_clockwise;
    logic                  m_too_few_points;

    // Predictor state: the tracked bottom-left vertex and its neighbours.
    point_t       origin_pt;
    point_t       latest_pt;
    point_t       low_pt;
    point_t       low_prev;
    point_t       low_next;
    logic         low_at_origin;
    logic         want_next;
    int           vertex_seen;

    orientation_t orientation_q[$];
    orientation_t oldest;
    int           fail_count = 0;
    int           mismatch_count = 0;
    int           random_items = 0;
    logic         sender_burst = 1'b0;
    int           ready_hold = 0;

    // The directed part: single and two-vertex polygons, the coordinate
    // extremes, both turning senses, a collinear and a degenerate polygon, a
    // tie on y resolved by x, and a corner that falls on the final vertex so
    // that its successor wraps round to the first.
    vertex_row_t vertex_table [TABLE_ROWS] = '{
        '{32'h0,          32'h0,          1'b1, 1'b1, 1'b0, 1'b1},
        '{C_MAX,          C_MAX,          1'b0, 1'b0, 1'b0, 1'b0},
        '{C_MIN,          C_MIN,          1'b1, 1'b1, 1'b0, 1'b1},
        '{32'h0,          32'h0,          1'b0, 1'b0, 1'b0, 1'b0},
        '{C_ONE,          32'h0,          1'b0, 1'b0, 1'b0, 1'b0},
        '{32'h0,          C_ONE,          1'b1, 1'b0, 1'b0, 1'b0},
        '{32'h0,          32'h0,          1'b0, 1'b0, 1'b0, 1'b0},
        '{32'h0,          C_ONE,          1'b0, 1'b0, 1'b0, 1'b0},
        '{C_ONE,          32'h0,          1'b1, 1'b0, 1'b0, 1'b0},
        '{32'h0,          32'h0,          1'b0, 1'b0, 1'b0, 1'b0},
        '{32'h1,          32'h0,          1'b0, 1'b0, 1'b0, 1'b0},
        '{32'h2,          32'h0,          1'b1, 1'b1, 1'b0, 1'b0},
        '{C_MIN,          C_MIN,          1'b0, 1'b0, 1'b0, 1'b0},
        '{C_MAX,          C_MIN,          1'b0, 1'b0, 1'b0, 1'b0},
        '{C_MAX,          C_MAX,          1'b0, 1'b0, 1'b0, 1'b0},
        '{C_MIN,          C_MAX,          1'b1, 1'b0, 1'b0, 1'b0},
        '{32'h5,          32'h5,          1'b0, 1'b0, 1'b0, 1'b0},
        '{32'h5,          32'h5,          1'b0, 1'b0, 1'b0, 1'b0},
        '{32'h5,          32'h5,          1'b1, 1'b1, 1'b0, 1'b0},
        '{32'h3,          32'h0,          1'b0, 1'b0, 1'b0, 1'b0},
        '{32'h1,          32'h0,          1'b0, 1'b0, 1'b0, 1'b0},
        '{32'h2,          32'h5,          1'b1, 1'b0, 1'b0, 1'b0},
        '{32'h0,          32'h5,          1'b0, 1'b0, 1'b0, 1'b0},
        '{32'h3,          32'h4,          1'b0, 1'b0, 1'b0, 1'b0},
        '{32'h1,          32'hffff_ffff,  1'b1, 1'b0, 1'b0, 1'b0}
    };

    polygon_orientation_test u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_x_coord        (s_x_coord),
        .s_y_coord        (s_y_coord),
        .s_last_vertex    (s_last_vertex),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_is_clockwise   (m_is_clockwise),
        .m_too_few_points (m_too_few_points)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Only the low COORD_BITS bits of a coordinate count, taken as signed.
    function automatic longint to_coord(input logic [31:0] raw);
        logic [63:0] wide;
        wide = {32'h0, raw} << (64 - COORD_BITS_DEF);
        return $signed(wide) >>> (64 - COORD_BITS_DEF);
    endfunction

    function automatic void clear_tracker();
        origin_pt     = '{0, 0};
        latest_pt     = '{0, 0};
        low_pt        = '{0, 0};
        low_prev      = '{0, 0};
        low_next      = '{0, 0};
        low_at_origin = 1'b1;
        want_next     = 1'b0;
        vertex_seen   = 0;
    endfunction

    // Advances the tracker by one accepted vertex. Returns 1 when the vertex
    // closes a polygon, with the orientation it should produce.
    function automatic bit predict_orientation(input logic [31:0] xr, input logic [31:0] yr,
                                               input logic last, output orientation_t res);
        point_t                v;
        point_t                a;
        point_t                c;
        logic signed [127:0]   bx;
        logic signed [127:0]   by;
        logic signed [127:0]   cx;
        logic signed [127:0]   cy;
        v.x = to_coord(xr);
        v.y = to_coord(yr);
        res = '{1'b0, 1'b0};
        if (vertex_seen == 0) begin
            origin_pt     = v;
            low_pt        = v;
            low_at_origin = 1'b1;
            want_next     = 1'b1;
        end else begin
            if (want_next) begin
                low_next  = v;
                want_next = 1'b0;
            end
            // Strict compare, so the earliest of equal vertices keeps the corner.
            if (v.y < low_pt.y || (v.y == low_pt.y && v.x < low_pt.x)) begin
                low_pt        = v;
                low_prev      = latest_pt;
                low_at_origin = 1'b0;
                want_next     = 1'b1;
            end
        end
        latest_pt = v;
        if (vertex_seen < 3)
            vertex_seen++;
        if (!last)
            return 0;
        if (vertex_seen < 3) begin
            res.too_few = 1'b1;
        end else begin
            // The predecessor of the first vertex is the final one, and the
            // successor of the final one is the first.
            a  = low_at_origin ? v : low_prev;
            c  = want_next ? origin_pt : low_next;
            bx = low_pt.x - a.x;
            by = low_pt.y - a.y;
            cx = c.x - a.x;
            cy = c.y - a.y;
            res.clockwise = (bx * cy) < (by * cx);
        end
        clear_tracker();
        return 1;
    endfunction

    // Mostly back-to-back, sometimes a short pause, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (sender_burst || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic [31:0] pick_coord(input coord_mode_e mode);
        logic [31:0] offs;
        offs = $urandom_range(0, 15);
        case (mode)
            COORD_FULL: begin
                return $urandom;
            end
            COORD_GRID: begin
                return ($urandom_range(0, 16) - 8) * C_ONE;
            end
            COORD_EDGE: begin
                return $urandom_range(0, 1) ? C_MAX - offs : C_MIN + offs;
            end
            default: begin
                // A handful of values, so that equal coordinates and ties on
                // y come up often.
                return $urandom_range(0, 3) - 1;
            end
        endcase
    endfunction

    // Offers one vertex request and holds it until accepted. The expected
    // result is queued at the edge on which the request is taken.
    task automatic send_vertex(input logic [31:0] xr, input logic [31:0] yr,
                               input logic last, input logic typed,
                               input orientation_t typed_res);
        int           gap;
        orientation_t res;
        gap = pick_gap();
        for (int i = 0; i < gap; i++) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_x_coord     <= xr;
        s_y_coord     <= yr;
        s_last_vertex <= last;
        do
            @(posedge aclk);
        while (!s_ready);
        if (predict_orientation(xr, yr, last, res))
            orientation_q.push_back(typed ? typed_res : res);
    endtask

    task automatic send_polygon();
        int          count;
        int          r;
        coord_mode_e mode;
        r = $urandom_range(0, 99);
        // Short polygons exercise the too-few path; most are proper polygons.
        if (r < 12)
            count = $urandom_range(1, 2);
        else if (r < 82)
            count = $urandom_range(3, 6);
        else
            count = $urandom_range(7, 12);
        mode         = coord_mode_e'($urandom_range(0, 3));
        sender_burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < count; i++) begin
            send_vertex(pick_coord(mode), pick_coord(mode), i == count - 1, 1'b0, '{0, 0});
            random_items++;
        end
    endtask

    // The receiver alternates between ready stretches and stalls of varied
    // length, including long stretches without any stall.
    always @(negedge aclk) begin
        if (ready_hold == 0) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
                    m_ready    <= 1'b1;
                    ready_hold = $urandom_range(1, 8);
                end
                10, 11, 12, 13, 14, 15, 16: begin
                    m_ready    <= 1'b0;
                    ready_hold = $urandom_range(1, 3);
                end
                17, 18: begin
                    m_ready    <= 1'b1;
                    ready_hold = $urandom_range(20, 60);
                end
                default: begin
                    m_ready    <= 1'b0;
                    ready_hold = $urandom_range(10, 30);
                end
            endcase
        end else begin
            ready_hold--;
        end
    end

    // Each result taken is matched against the oldest expected orientation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (orientation_q.size() == 0) begin
                fail_count++;
                if (mismatch_count < REPORT_LIMIT)
                    $display("unexpected result: is_clockwise=%0b too_few_points=%0b",
                             m_is_clockwise, m_too_few_points);
                mismatch_count++;
            end else begin
                oldest = orientation_q.pop_front();
                if (m_is_clockwise !== oldest.clockwise ||
                        m_too_few_points !== oldest.too_few) begin
                    fail_count++;
                    if (mismatch_count < REPORT_LIMIT)
                        $display("mismatch: is_clockwise exp %0b got %0b, too_few_points exp %0b got %0b",
                                 oldest.clockwise, m_is_clockwise,
                                 oldest.too_few, m_too_few_points);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

    initial begin
        clear_tracker();
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table first, with its typed-in results where given.
        for (int i = 0; i < TABLE_ROWS; i++)
            send_vertex(vertex_table[i].x, vertex_table[i].y, vertex_table[i].last,
                        vertex_table[i].typed,
                        '{vertex_table[i].clockwise, vertex_table[i].too_few});

        // Random polygons. Halfway through, the sender holds back until every
        // outstanding result has been delivered, so the block runs fully empty.
        while (random_items < RANDOM_ITEMS / 2)
            send_polygon();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (orientation_q.size() != 0)
            @(posedge aclk);
        while (random_items < RANDOM_ITEMS)
            send_polygon();

        @(negedge aclk);
        s_valid <= 1'b0;
        while (orientation_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && orientation_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
